[hdl/cfd_pkg.sv]
// Shared types, constants and the CRC-8 byte step for the COBS deframer.
package cfd_pkg;

   // Receiver phase, one-hot
   typedef enum logic [2:0] {
      PH_HUNT    = 3'b001,
      PH_HEADER  = 3'b010,
      PH_PAYLOAD = 3'b100
   } phase_type;

   // Error codes carried in an error result
   localparam logic [1:0] ERR_HDR_CRC  = 2'd0;
   localparam logic [1:0] ERR_RAW_ZERO = 2'd1;
   localparam logic [1:0] ERR_TOO_LONG = 2'd2;
   localparam logic [1:0] ERR_EMPTY    = 2'd3;

   // Configuration register indexes
   localparam int unsigned CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_VALUE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PAYLOAD = 1'b1;

   localparam logic [7:0] SYNC_RESET     = 8'h00;
   localparam logic [7:0] MAX_PAY_RESET  = 8'hFF;

   // CRC-8/AUTOSAR
   localparam logic [7:0] CRC_POLY   = 8'h2F;
   localparam logic [7:0] CRC_INIT   = 8'hFF;
   localparam logic [7:0] CRC_XOROUT = 8'hFF;

   // Header byte positions after sync
   localparam logic [1:0] HDR_SERVICE = 2'd0;
   localparam logic [1:0] HDR_LENGTH  = 2'd1;
   localparam logic [1:0] HDR_OFFSET  = 2'd2;
   localparam logic [1:0] HDR_CRC     = 2'd3;

   typedef struct packed {
      phase_type  phase;
      logic [1:0] hdr_idx;
      logic [7:0] service;
      logic [7:0] length;
      logic [7:0] crc;
      logic [7:0] count;
      logic [7:0] zero_dist;
   } frame_state_type;

   typedef struct packed {
      logic       is_error;
      logic [7:0] data;
      logic [7:0] service;
      logic       last;
      logic [1:0] code;
   } result_type;

   // One byte through the MSB-first CRC, eight shift steps
   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

[hdl/cfd_step.sv]
// Per-byte next-state and result logic of the deframer.
module cfd_step (
   input  cfd_pkg::frame_state_type cur,
   input  logic [7:0]               in_byte,
   input  logic [7:0]               sync_value,
   input  logic [7:0]               max_payload,
   output cfd_pkg::frame_state_type nxt,
   output logic                     emit,
   output cfd_pkg::result_type      res
);

   logic [7:0] crc_final;
   logic [7:0] crc_chk;
   logic [7:0] count_inc;

   assign crc_final = cur.crc ^ cfd_pkg::CRC_XOROUT;
   assign crc_chk   = (crc_final == 8'h00) ? 8'hFF : crc_final;
   assign count_inc = cur.count + 8'd1;

   always_comb begin
      nxt  = cur;
      emit = 1'b0;
      res  = '0;
      case (cur.phase)
         cfd_pkg::PH_HEADER: begin
            if (cur.hdr_idx != cfd_pkg::HDR_CRC) begin
               case (cur.hdr_idx)
                  cfd_pkg::HDR_SERVICE: nxt.service   = in_byte;
                  cfd_pkg::HDR_LENGTH:  nxt.length    = in_byte;
                  default:              nxt.zero_dist = in_byte;
               endcase
               nxt.crc     = cfd_pkg::crc8_step(cur.crc, in_byte);
               nxt.hdr_idx = cur.hdr_idx + 2'd1;
            end else begin
               nxt.hdr_idx = '0;
               nxt.count   = '0;
               if (crc_chk != in_byte) begin
                  emit      = 1'b1;
                  res.code  = cfd_pkg::ERR_HDR_CRC;
                  nxt.phase = cfd_pkg::PH_HUNT;
               end else if (cur.length == 8'h00) begin
                  emit      = 1'b1;
                  res.code  = cfd_pkg::ERR_EMPTY;
                  nxt.phase = cfd_pkg::PH_HUNT;
               end else if (cur.length > max_payload) begin
                  emit      = 1'b1;
                  res.code  = cfd_pkg::ERR_TOO_LONG;
                  nxt.phase = cfd_pkg::PH_HUNT;
               end else begin
                  nxt.phase = cfd_pkg::PH_PAYLOAD;
               end
               res.is_error = emit;
            end
         end
         cfd_pkg::PH_PAYLOAD: begin
            emit = 1'b1;
            if (in_byte == 8'h00) begin
               // raw zero is illegal inside stuffed payload
               res.is_error = 1'b1;
               res.code     = cfd_pkg::ERR_RAW_ZERO;
               nxt.phase    = cfd_pkg::PH_HUNT;
               nxt.hdr_idx  = '0;
               nxt.count    = '0;
            end else begin
               if (cur.zero_dist == 8'd1) begin
                  res.data      = 8'h00;
                  nxt.zero_dist = in_byte;
               end else begin
                  res.data      = in_byte;
                  nxt.zero_dist = cur.zero_dist - 8'd1;
               end
               res.service = cur.service;
               nxt.count   = count_inc;
               if (count_inc == cur.length) begin
                  res.last    = 1'b1;
                  nxt.phase   = cfd_pkg::PH_HUNT;
                  nxt.hdr_idx = '0;
                  nxt.count   = '0;
               end
            end
         end
         default: begin
            nxt.phase = cfd_pkg::PH_HUNT;
            if (in_byte == sync_value) begin
               nxt.phase   = cfd_pkg::PH_HEADER;
               nxt.hdr_idx = '0;
               nxt.crc     = cfd_pkg::CRC_INIT;
            end
         end
      endcase
   end

endmodule

[hdl/crc_framed_zero_stuffed_deframer.sv]
// Sync-led COBS deframer with CRC-8/AUTOSAR header: top level.
// An accepted byte is held in the input register; any result it makes is registered in the result register.
// Throughput: one byte per cycle; the input register advances whenever the
//   result register is empty or being drained.
// Reset (synchronous, active high): hunting for sync, sync_value 0,
//   max_payload 255, no byte held, no result pending.
module crc_framed_zero_stuffed_deframer (
   input  logic                         clock,
   input  logic                         reset,
   // input byte channel
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [7:0]                   req_in_byte,
   // result channel
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_is_error,
   output logic [7:0]                   rsp_out_data,
   output logic [7:0]                   rsp_service_id,
   output logic                         rsp_last_byte,
   output logic [1:0]                   rsp_error_code,
   // configuration writes
   input  logic                         csr_write_en,
   input  logic [cfd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]                   csr_wdata
);

   // config registers
   logic [7:0] sync_ff, sync_in;
   logic [7:0] max_pay_ff, max_pay_in;

   // input register (one byte transaction held)
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;

   // frame state
   cfd_pkg::frame_state_type state_ff, state_in, state_nxt;

   // result register
   logic                 out_valid_ff, out_valid_in;
   cfd_pkg::result_type  out_ff, out_in, step_res;
   logic                 step_emit;

   logic advance;

   // The held byte moves on when the result slot is free or being taken.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   cfd_step u_step (
      .cur         (state_ff),
      .in_byte     (in_byte_ff),
      .sync_value  (sync_ff),
      .max_payload (max_pay_ff),
      .nxt         (state_nxt),
      .emit        (step_emit),
      .res         (step_res)
   );

   always_comb begin
      sync_in    = sync_ff;
      max_pay_in = max_pay_ff;
      if (csr_write_en) begin
         case (csr_index)
            cfd_pkg::CSR_SYNC_VALUE:  sync_in    = csr_wdata;
            cfd_pkg::CSR_MAX_PAYLOAD: max_pay_in = csr_wdata;
            default: ;
         endcase
      end

      // input side
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_in_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      // state moves only when a byte is consumed
      state_in = advance ? state_nxt : state_ff;

      // result side: hunting and header bytes leave the slot empty, but a failed header check byte emits an error
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (advance) begin
         out_valid_in = step_emit;
         if (step_emit) begin
            out_in = step_res;
         end
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff            <= cfd_pkg::SYNC_RESET;
         max_pay_ff         <= cfd_pkg::MAX_PAY_RESET;
         in_valid_ff        <= 1'b0;
         out_valid_ff       <= 1'b0;
         state_ff.phase     <= cfd_pkg::PH_HUNT;
         state_ff.hdr_idx   <= '0;
         state_ff.service   <= '0;
         state_ff.length    <= '0;
         state_ff.crc       <= cfd_pkg::CRC_INIT;
         state_ff.count     <= '0;
         state_ff.zero_dist <= '0;
      end else begin
         sync_ff      <= sync_in;
         max_pay_ff   <= max_pay_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      out_ff     <= out_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_is_error   = out_ff.is_error;
   assign rsp_out_data   = out_ff.data;
   assign rsp_service_id = out_ff.service;
   assign rsp_last_byte  = out_ff.last;
   assign rsp_error_code = out_ff.code;

endmodule
